[src/stoi_pkg.sv]
// stoi_pkg: shared types, constants and character class helpers for the
// radix string parser. No dependencies.
package stoi_pkg;

    // widths fixed by the register and field formats
    localparam int CHAR_W    = 8;
    localparam int VALUE_W   = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 2;
    localparam int RADIX_W   = 5;
    localparam int DIGIT_W   = 4;

    // largest radix the alphabet storage can hold
    localparam int MAX_RADIX_DEF = 16;

    // reset radix
    localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LEN  = 2'd2;

    // character codes
    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

    // parse phase, one-hot
    typedef enum logic [3:0] {
        PH_SPACE = 4'b0001,
        PH_SIGN  = 4'b0010,
        PH_DIGIT = 4'b0100,
        PH_DONE  = 4'b1000
    } t_phase;

    // digit lookup result for one character
    typedef struct packed {
        logic                 is_digit;
        logic [DIGIT_W-1:0]   digit;
        logic [RADIX_W-1:0]   radix;
    } t_digit_info;

    function automatic logic is_space(input logic [CHAR_W-1:0] c);
        return c inside {CH_SPACE, CH_FF, CH_LF, CH_CR, CH_TAB, CH_VT};
    endfunction

    function automatic logic is_sign(input logic [CHAR_W-1:0] c);
        return c inside {CH_PLUS, CH_MINUS};
    endfunction

endpackage

[src/string_to_integer_any_base_unit.sv]
// string_to_integer_any_base_unit: top level of the radix string parser.
// Depends on stoi_pkg and stoi_alphabet.
//
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+------------------------------
//  in       | to block  | i_in_valid/o_in_stall  | i_char_in, i_string_start
//  out      | from block| o_out_valid/i_out_stall| o_value_out
//  cfg      | to block  | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
//
// One character per cycle while o_in_stall is low. The character that ends the
// number is taken into the input register, which feeds the update of the parse
// state and accumulator, one 32x5 multiply-add, into the result register.
// Reset is synchronous, active low; o_cfg_ready is always high.
// A stalled result holds the result register; one more character is taken into
// the input register and then o_in_stall rises until the result is taken.
module string_to_integer_any_base_unit
    import stoi_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [CHAR_W-1:0]         i_char_in,
    input  logic                      i_string_start,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [VALUE_W-1:0] o_value_out,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_W-1:0]          i_cfg_data
);

    logic                r_in_vld;
    logic [CHAR_W-1:0]   r_char;
    logic                r_start;
    t_phase              r_phase;
    t_phase              n_phase;
    logic                r_neg;
    logic                n_neg;
    logic [VALUE_W-1:0]  r_acc;
    logic [VALUE_W-1:0]  n_acc;
    logic                r_out_vld;
    logic [VALUE_W-1:0]  r_value;
    logic                emit;
    logic                advance;
    logic                in_xfer;
    t_phase              cur_phase;
    logic                cur_neg;
    logic [VALUE_W-1:0]  cur_acc;
    t_digit_info         info;

    assign o_cfg_ready = 1'b1;

    // item moves from the input register into the parse state
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    stoi_alphabet #(
        .MAX_RADIX (MAX_RADIX)
    ) u_alphabet (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (r_char),
        .o_info      (info)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (advance) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char  <= i_char_in;
            r_start <= i_string_start;
        end
    end

    // string start restarts the parse with this character
    assign cur_phase = r_start ? PH_SPACE : r_phase;
    assign cur_neg   = r_start ? 1'b0 : r_neg;
    assign cur_acc   = r_start ? '0 : r_acc;

    // parse step: whitespace, sign run, digits, then done
    always_comb begin
        n_phase = cur_phase;
        n_neg   = cur_neg;
        n_acc   = cur_acc;
        emit    = 1'b0;
        if (cur_phase == PH_DONE) begin
            emit = 1'b0;
        end else if (cur_phase == PH_SPACE && is_space(r_char)) begin
            n_phase = PH_SPACE;
        end else if ((cur_phase == PH_SPACE || cur_phase == PH_SIGN) &&
                     is_sign(r_char)) begin
            n_phase = PH_SIGN;
            n_neg   = cur_neg ^ (r_char == CH_MINUS);
        end else if (info.is_digit) begin
            n_phase = PH_DIGIT;
            n_acc   = (cur_acc * VALUE_W'(info.radix)) + VALUE_W'(info.digit);
        end else begin
            n_phase = PH_DONE;
            emit    = 1'b1;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SPACE;
            r_neg   <= 1'b0;
            r_acc   <= '0;
        end else if (advance) begin
            r_phase <= n_phase;
            r_neg   <= n_neg;
            r_acc   <= n_acc;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= emit;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_value <= cur_neg ? (VALUE_W'(0) - cur_acc) : cur_acc;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_value_out = r_value;

endmodule

[src/stoi_alphabet.sv]
// stoi_alphabet: alphabet configuration registers, registered alphabet check
// and parallel digit lookup. Depends on stoi_pkg.
module stoi_alphabet
    import stoi_pkg::*;
#(
    parameter int MAX_RADIX = MAX_RADIX_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [CHAR_W-1:0]    i_char,
    output t_digit_info          o_info
);

    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(MAX_RADIX);

    logic [CFG_W-1:0]   r_low;
    logic [CFG_W-1:0]   r_high;
    logic [RADIX_W-1:0] r_len;
    logic               r_alpha_ok;
    logic               n_alpha_ok;
    logic [RADIX_W-1:0] radix;
    logic [2*CFG_W-1:0] alpha;
    logic               hit_any;
    logic [DIGIT_W-1:0] hit_digit;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= '0;
            r_high <= '0;
            r_len  <= RADIX_RESET;
        end else if (i_cfg_wr) begin
            case (i_cfg_index)
                CFG_ALPHA_LOW:  r_low  <= i_cfg_data;
                CFG_ALPHA_HIGH: r_high <= i_cfg_data;
                CFG_ALPHA_LEN:  r_len  <= i_cfg_data[RADIX_W-1:0];
                default: ;
            endcase
        end
    end

    // radix saturates at the storage limit
    assign radix = (r_len > RADIX_MAX) ? RADIX_MAX : r_len;
    assign alpha = {r_high, r_low};

    // alphabet check: radix of at least two, no NUL, sign, space or repeat
    always_comb begin
        n_alpha_ok = (radix >= RADIX_W'(2));
        for (int a = 0; a < MAX_RADIX; a++) begin
            if (RADIX_W'(a) < radix) begin
                if (alpha[8*a +: 8] == CH_NUL || is_space(alpha[8*a +: 8]) ||
                    is_sign(alpha[8*a +: 8])) begin
                    n_alpha_ok = 1'b0;
                end
                for (int b = a + 1; b < MAX_RADIX; b++) begin
                    if (RADIX_W'(b) < radix && alpha[8*b +: 8] == alpha[8*a +: 8]) begin
                        n_alpha_ok = 1'b0;
                    end
                end
            end
        end
    end

    // check result is registered and settles in the cycle after a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_ok <= 1'b0;
        end else begin
            r_alpha_ok <= n_alpha_ok;
        end
    end

    // parallel compare against the used characters; at most one hits when no character repeats
    always_comb begin
        hit_any   = 1'b0;
        hit_digit = '0;
        for (int k = 0; k < MAX_RADIX; k++) begin
            if (RADIX_W'(k) < radix && alpha[8*k +: 8] == i_char) begin
                hit_any   = 1'b1;
                hit_digit = hit_digit | DIGIT_W'(k);
            end
        end
    end

    assign o_info.is_digit = r_alpha_ok && hit_any;
    assign o_info.digit    = hit_digit;
    assign o_info.radix    = radix;

endmodule

[src/stoi_checker.sv]
// stoi_checker: port-level assertions for the radix string parser, bound to
// the top level. Depends on stoi_pkg.
module stoi_checker
    import stoi_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_in_stall,
    input logic                      o_out_valid,
    input logic                      i_out_stall,
    input logic signed [VALUE_W-1:0] o_value_out
);

    // a held result keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_value_out))
        else $error("result changed while stalled");

    // input backs up only behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // reset leaves the input open
    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall)
        else $error("input stalled after reset");

endmodule

bind string_to_integer_any_base_unit stoi_checker u_stoi_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value_out (o_value_out)
);

[tb/sv/testbench.sv]
// testbench: self-checking bench for string_to_integer_any_base_unit.
// Sends character transfers and alphabet writes, predicts every parsed value and
// checks each output transfer in order. Depends on stoi_pkg and the block.
module testbench;
    import stoi_pkg::*;

    localparam int CLK_HALF         = 6;
    localparam int RESET_CYCLES     = 10;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 6;
    localparam int PHASE_ITEMS      = 160;
    localparam int RANDOM_PHASES    = 9;

    // index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // "01234567", "89" and "89ABCDEF" packed with digit 0 in the low byte
    localparam logic [CFG_W-1:0] DECIMAL_LOW  = 64'h3736_3534_3332_3130;
    localparam logic [CFG_W-1:0] DECIMAL_HIGH = 64'h0000_0000_0000_3938;
    localparam logic [CFG_W-1:0] HEX_HIGH     = 64'h4645_4443_4241_3938;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              start;
    } t_char_item;

    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;
    typedef enum {ALPHA_DECIMAL, ALPHA_HEX, ALPHA_RANDOM, ALPHA_HEX_WIDE, ALPHA_BROKEN}
        t_alpha_kind;

    logic                      i_clk          = 1'b0;
    logic                      i_rst_n        = 1'b0;
    logic                      i_in_valid     = 1'b0;
    logic                      o_in_stall;
    logic [CHAR_W-1:0]         i_char_in      = '0;
    logic                      i_string_start = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_stall    = 1'b0;
    logic signed [VALUE_W-1:0] o_value_out;
    logic                      i_cfg_valid    = 1'b0;
    logic                      o_cfg_ready;
    logic [CFG_IDX_W-1:0]      i_cfg_index    = '0;
    logic [CFG_W-1:0]          i_cfg_data     = '0;

    string_to_integer_any_base_unit u_dut (.*);

    // predictor copy of registers and parse state
    logic [CFG_W-1:0]   model_alpha_low  = '0;
    logic [CFG_W-1:0]   model_alpha_high = '0;
    logic [RADIX_W-1:0] model_length     = RADIX_RESET;
    t_phase             model_phase      = PH_SPACE;
    logic               model_negative   = 1'b0;
    logic [VALUE_W-1:0] model_acc        = '0;

    t_char_item                chars_to_send[$];
    logic signed [VALUE_W-1:0] parsed_values_due[$];
    logic [CHAR_W-1:0]         digit_chars[$];

    int          errors       = 0;
    int          idle_cycles  = 0;
    bit          in_fired     = 1'b0;
    bit          hold_request = 1'b0;
    int          burst_left   = 0;
    int          gap_left     = 0;
    int          hold_left    = 0;
    int          mode_left    = 0;
    int          stall_period = 2;
    int          stall_tick   = 0;
    t_stall_mode stall_mode   = STALL_NONE;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    function automatic logic blank_char(input logic [CHAR_W-1:0] c);
        return c == CH_SPACE || c == CH_FF || c == CH_LF || c == CH_CR ||
               c == CH_TAB || c == CH_VT;
    endfunction

    function automatic logic sign_char(input logic [CHAR_W-1:0] c);
        return c == CH_PLUS || c == CH_MINUS;
    endfunction

    function automatic int used_radix();
        return (model_length > MAX_RADIX_DEF) ? MAX_RADIX_DEF : int'(model_length);
    endfunction

    function automatic logic [CHAR_W-1:0] alpha_at(input int k);
        logic [2*CFG_W-1:0] both;
        both = {model_alpha_high, model_alpha_low};
        return both[8*k +: 8];
    endfunction

    // position of c in the alphabet, -1 when not a digit or alphabet unusable
    function automatic int digit_value(input logic [CHAR_W-1:0] c);
        int n;
        int a;
        int b;
        logic [CHAR_W-1:0] ca;
        n = used_radix();
        if (n < 2)
            return -1;
        for (a = 0; a < n; a++) begin
            ca = alpha_at(a);
            if (ca == CH_NUL || blank_char(ca) || sign_char(ca))
                return -1;
            for (b = a + 1; b < n; b++)
                if (alpha_at(b) == ca)
                    return -1;
        end
        for (a = 0; a < n; a++)
            if (alpha_at(a) == c)
                return a;
        return -1;
    endfunction

    // advance the predicted parse by one character
    task automatic parse_char(input logic [CHAR_W-1:0] c, input logic st,
                              output logic made, output logic [VALUE_W-1:0] value);
        int d;
        made  = 1'b0;
        value = '0;
        if (st) begin
            model_phase    = PH_SPACE;
            model_negative = 1'b0;
            model_acc      = '0;
        end
        if (model_phase == PH_DONE)
            return;
        if (model_phase == PH_SPACE) begin
            if (blank_char(c))
                return;
            model_phase = PH_SIGN;
        end
        if (model_phase == PH_SIGN) begin
            if (sign_char(c)) begin
                if (c == CH_MINUS)
                    model_negative = ~model_negative;
                return;
            end
            model_phase = PH_DIGIT;
        end
        d = digit_value(c);
        if (d >= 0) begin
            model_acc = model_acc * VALUE_W'(used_radix()) + VALUE_W'(d);
            return;
        end
        model_phase = PH_DONE;
        made        = 1'b1;
        value       = model_negative ? (VALUE_W'(0) - model_acc) : model_acc;
    endtask

    // monitor: checks results, feeds predictor, tracks register writes
    always @(posedge i_clk) begin
        logic made;
        logic [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] want;
        bit moved;
        moved    = 1'b0;
        in_fired = 1'b0;
        if (i_rst_n) begin
            // result transfer against the oldest prediction
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (parsed_values_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %0d",
                             $time, o_value_out);
                    errors++;
                end else begin
                    want = parsed_values_due.pop_front();
                    if (o_value_out !== want) begin
                        $display("%0t: value_out mismatch, expected %0d, actual %0d",
                                 $time, want, o_value_out);
                        errors++;
                    end
                end
            end
            // character transfer
            if (i_in_valid && !o_in_stall) begin
                moved    = 1'b1;
                in_fired = 1'b1;
                parse_char(i_char_in, i_string_start, made, value);
                if (made)
                    parsed_values_due.push_back(value);
            end
            // register write transfer
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    CFG_ALPHA_LOW:  model_alpha_low  = i_cfg_data;
                    CFG_ALPHA_HIGH: model_alpha_high = i_cfg_data;
                    CFG_ALPHA_LEN:  model_length     = i_cfg_data[RADIX_W-1:0];
                    default: ;
                endcase
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    // character driver: bursts with random gaps, payload held until taken
    always @(negedge i_clk) begin
        bit offer;
        offer = 1'b0;
        if (in_fired)
            void'(chars_to_send.pop_front());
        if (!i_rst_n) begin
            offer = 1'b0;
        end else if (i_in_valid && !in_fired) begin
            offer = 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
        end else if (chars_to_send.size() > 0) begin
            offer = 1'b1;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            end
        end
        i_in_valid <= offer;
        if (offer) begin
            i_char_in      <= chars_to_send[0].ch;
            i_string_start <= chars_to_send[0].start;
        end
    end

    // result stall pattern, with one long hold on request
    always @(negedge i_clk) begin
        bit stall;
        if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode   = t_stall_mode'($urandom_range(0, 3));
                mode_left    = $urandom_range(20, 200);
                stall_period = $urandom_range(2, 10);
            end
            mode_left--;
            stall_tick++;
            case (stall_mode)
                STALL_NONE:  stall = 1'b0;
                STALL_LIGHT: stall = ($urandom_range(0, 9) < 3);
                STALL_HEAVY: stall = ($urandom_range(0, 9) < 8);
                default:     stall = (stall_tick % stall_period) < (stall_period / 2);
            endcase
        end
        i_out_stall <= stall;
    end

    task automatic push_char(input logic [CHAR_W-1:0] c, input logic st);
        t_char_item item;
        item.ch    = c;
        item.start = st;
        chars_to_send.push_back(item);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // write all alphabet registers and note the used characters for stimulus
    task automatic set_alphabet(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi,
                                input logic [RADIX_W-1:0] len);
        logic [2*CFG_W-1:0] both;
        int k;
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, {$urandom, $urandom});
        write_reg(CFG_ALPHA_LOW, lo);
        write_reg(CFG_ALPHA_HIGH, hi);
        write_reg(CFG_ALPHA_LEN, CFG_W'(len));
        both = {hi, lo};
        digit_chars.delete();
        for (k = 0; k < ((len > MAX_RADIX_DEF) ? MAX_RADIX_DEF : int'(len)); k++)
            digit_chars.push_back(both[8*k +: 8]);
    endtask

    // block is idle once all characters went in and all values came out
    task automatic wait_idle();
        while (chars_to_send.size() != 0 || parsed_values_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    function automatic logic [CHAR_W-1:0] pick_blank();
        case ($urandom_range(0, 5))
            0:       return CH_SPACE;
            1:       return CH_FF;
            2:       return CH_LF;
            3:       return CH_CR;
            4:       return CH_TAB;
            default: return CH_VT;
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit();
        if (digit_chars.size() == 0)
            return CHAR_W'($urandom_range(0, 255));
        return digit_chars[$urandom_range(0, digit_chars.size() - 1)];
    endfunction

    // distinct usable characters for the used slots, anything in the rest;
    // broken alphabets of length two or more get one used slot spoiled
    task automatic make_alphabet(input int len, input bit broken,
                                 output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi);
        logic [CHAR_W-1:0] chars[16];
        logic [CHAR_W-1:0] c;
        int k;
        int j;
        bit clash;
        for (k = 0; k < 16; k++) begin
            if (k < len) begin
                do begin
                    c     = CHAR_W'($urandom_range(1, 255));
                    clash = blank_char(c) || sign_char(c);
                    for (j = 0; j < k; j++)
                        if (chars[j] == c)
                            clash = 1'b1;
                end while (clash);
                chars[k] = c;
            end else begin
                chars[k] = CHAR_W'($urandom_range(0, 255));
            end
        end
        if (broken && len >= 2) begin
            j = $urandom_range(0, len - 1);
            case ($urandom_range(0, 3))
                0:       chars[j] = chars[(j + 1) % len];
                1:       chars[j] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
                2:       chars[j] = pick_blank();
                default: chars[j] = CH_NUL;
            endcase
        end
        for (k = 0; k < 8; k++) begin
            lo[8*k +: 8] = chars[k];
            hi[8*k +: 8] = chars[k + 8];
        end
    endtask

    // whitespace, signs, digits, then optionally a terminator and an ignored tail
    task automatic push_string(input bit finish, output int counted);
        int n;
        int r;
        bit first;
        logic [CHAR_W-1:0] term;
        first   = 1'b1;
        counted = 0;
        n = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 4);
        repeat (n) begin
            push_char(pick_blank(), first);
            first = 1'b0;
            counted++;
        end
        r = $urandom_range(0, 9);
        n = (r < 5) ? 0 : (r < 8) ? 1 : $urandom_range(2, 4);
        repeat (n) begin
            push_char($urandom_range(0, 1) ? CH_MINUS : CH_PLUS, first);
            first = 1'b0;
            counted++;
        end
        n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8) : $urandom_range(9, 40);
        repeat (n) begin
            push_char(pick_digit(), first);
            first = 1'b0;
            counted++;
        end
        if (finish) begin
            case ($urandom_range(0, 3))
                0, 1:    term = CH_NUL;
                2:       term = CHAR_W'($urandom_range(0, 255));
                default: term = $urandom_range(0, 1) ? pick_blank() : CH_PLUS;
            endcase
            push_char(term, 1'b0);
            counted++;
            repeat ($urandom_range(0, 2)) begin
                push_char(CHAR_W'($urandom_range(0, 255)), 1'b0);
                counted++;
            end
        end
    endtask

    initial begin
        bit timed_out;
        int p;
        int n;
        int r;
        int phase_count;
        t_alpha_kind kind;
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        timed_out = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        fork
            begin
                // reset alphabet is all NUL, no string start before the first string
                push_char(CH_SPACE, 1'b0);
                push_char(CH_MINUS, 1'b0);
                push_char(8'hFF, 1'b0);
                push_char(CH_NUL, 1'b1);
                wait_idle();

                // decimal: every whitespace but space, mixed signs, then "42" and NUL
                set_alphabet(DECIMAL_LOW, DECIMAL_HIGH, 5'd10);
                push_char(CH_TAB, 1'b1);
                push_char(CH_VT, 1'b0);
                push_char(CH_FF, 1'b0);
                push_char(CH_CR, 1'b0);
                push_char(CH_LF, 1'b0);
                push_char(CH_MINUS, 1'b0);
                push_char(CH_PLUS, 1'b0);
                push_char(8'h34, 1'b0);
                push_char(8'h32, 1'b0);
                push_char(CH_NUL, 1'b0);
                // unfinished "12" dropped by a new start, tail after "7x" ignored
                push_char(8'h31, 1'b1);
                push_char(8'h32, 1'b0);
                push_char(8'h37, 1'b1);
                push_char(8'h78, 1'b0);
                push_char(8'h33, 1'b0);
                wait_idle();

                // length above the radix limit saturates to 16
                set_alphabet(DECIMAL_LOW, HEX_HIGH, 5'd31);
                push_char(CH_MINUS, 1'b1);
                push_char(8'h46, 1'b0);
                push_char(CH_SPACE, 1'b0);
                wait_idle();

                // zero length: nothing is a digit
                set_alphabet('1, '1, 5'd0);
                push_char(8'h30, 1'b1);
                push_char(8'h30, 1'b0);

                for (p = 0; p < RANDOM_PHASES; p++) begin
                    wait_idle();
                    if (p == 2)
                        kind = ALPHA_HEX_WIDE;
                    else if (p == 5)
                        kind = ALPHA_BROKEN;
                    else
                        kind = t_alpha_kind'($urandom_range(0, 2));
                    case (kind)
                        ALPHA_DECIMAL:
                            set_alphabet(DECIMAL_LOW,
                                         {$urandom, 16'($urandom), DECIMAL_HIGH[15:0]}, 5'd10);
                        ALPHA_HEX:
                            set_alphabet(DECIMAL_LOW, HEX_HIGH, 5'd16);
                        ALPHA_HEX_WIDE:
                            set_alphabet(DECIMAL_LOW, HEX_HIGH, RADIX_W'($urandom_range(17, 31)));
                        ALPHA_RANDOM: begin
                            n = $urandom_range(2, 16);
                            make_alphabet(n, 1'b0, lo, hi);
                            set_alphabet(lo, hi, RADIX_W'(n));
                        end
                        default: begin
                            if ($urandom_range(0, 3) == 0)
                                n = $urandom_range(0, 1);
                            else
                                n = $urandom_range(2, 16);
                            make_alphabet(n, 1'b1, lo, hi);
                            set_alphabet(lo, hi, RADIX_W'(n));
                        end
                    endcase
                    // fill the block while the result side holds off
                    if (p == 3)
                        hold_request = 1'b1;
                    phase_count = 0;
                    while (phase_count < PHASE_ITEMS) begin
                        r = $urandom_range(0, 99);
                        if (r < 80) begin
                            push_string(1'b1, n);
                        end else if (r < 90) begin
                            n = $urandom_range(1, 6);
                            repeat (n)
                                push_char(CHAR_W'($urandom_range(0, 255)),
                                          $urandom_range(0, 3) == 0);
                        end else begin
                            push_string(1'b0, n);
                        end
                        phase_count += n;
                    end
                end
                wait_idle();
            end
            begin
                wait (idle_cycles >= WATCHDOG_LIMIT);
                timed_out = 1'b1;
            end
        join_any

        if (!timed_out && errors == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
